[rtl/core/zrle_pkg.sv]
// ----------------------------------------------------------------------------
// zrle_pkg
// Shared widths and types for the zero run-length encoder.
// ----------------------------------------------------------------------------
package zrle_pkg;

  localparam int WORD_BITS = 16;
  localparam int CNT_BITS  = 16;
  localparam int NUM_BITS  = 2;

  localparam logic [CNT_BITS-1:0] RUN_LIMIT_RESET = CNT_BITS'(65000);

  localparam logic [WORD_BITS-1:0] RUN_MARKER = '0;

  // Results for one input item, handed from the encoder to the emitter.
  typedef struct packed {
    logic                 load;
    logic [NUM_BITS-1:0]  num;
    logic                 eob;
    logic [WORD_BITS-1:0] v0;
    logic [WORD_BITS-1:0] v1;
    logic [WORD_BITS-1:0] v2;
  } burst_t;

endpackage

[rtl/core/zrle_encode.sv]
// ----------------------------------------------------------------------------
// zrle_encode
// Input register, run limit register and zero counter; builds the result
// burst of one input word.
// ----------------------------------------------------------------------------
module zrle_encode (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [zrle_pkg::WORD_BITS-1:0] word,
  input  logic                          end_of_block,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [zrle_pkg::CNT_BITS-1:0] cfg_data,
  input  logic                          burst_free,
  output zrle_pkg::burst_t              burst
);
  import zrle_pkg::*;

  logic                 item_valid;
  logic [WORD_BITS-1:0] word_q;
  logic                 eob_q;
  logic [CNT_BITS-1:0]  run_limit;
  logic [CNT_BITS-1:0]  zero_count;
  logic [CNT_BITS-1:0]  zero_count_next;
  logic [CNT_BITS-1:0]  cnt1;
  logic                 item_take;
  logic [NUM_BITS-1:0]  num;

  assign cfg_ready = 1'b1;
  assign item_take = item_valid && burst_free;
  assign in_ready  = !item_valid || item_take;
  assign cnt1      = zero_count + CNT_BITS'(1);

  always_comb begin
    num             = '0;
    zero_count_next = zero_count;
    burst.v0        = RUN_MARKER;
    burst.v1        = RUN_MARKER;
    burst.v2        = RUN_MARKER;
    if (word_q == '0) begin
      if (cnt1 >= run_limit || eob_q) begin
        num             = NUM_BITS'(2);
        burst.v1        = WORD_BITS'(cnt1);
        zero_count_next = '0;
      end else begin
        zero_count_next = cnt1;
      end
    end else begin
      zero_count_next = '0;
      if (zero_count != '0) begin
        num      = NUM_BITS'(3);
        burst.v1 = WORD_BITS'(zero_count);
        burst.v2 = word_q;
      end else begin
        num      = NUM_BITS'(1);
        burst.v0 = word_q;
      end
    end
    burst.num  = num;
    burst.eob  = eob_q;
    burst.load = item_take && (num != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      zero_count <= '0;
      run_limit  <= RUN_LIMIT_RESET;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
      end else if (item_take) begin
        item_valid <= 1'b0;
      end
      if (item_take) begin
        zero_count <= zero_count_next;
      end
      if (cfg_valid) begin
        run_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_q <= word;
      eob_q  <= end_of_block;
    end
  end

endmodule

[rtl/core/zrle_emit.sv]
// ----------------------------------------------------------------------------
// zrle_emit
// Holds one result burst and moves it, one word a cycle while out_ready allows,
// into the output register; flags the final result of the item and of the block.
// ----------------------------------------------------------------------------
module zrle_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  zrle_pkg::burst_t               burst,
  output logic                           burst_free,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [zrle_pkg::WORD_BITS-1:0] value,
  output logic                           last_of_item,
  output logic                           block_done
);
  import zrle_pkg::*;

  logic [NUM_BITS-1:0]  rem;
  logic [WORD_BITS-1:0] b0;
  logic [WORD_BITS-1:0] b1;
  logic [WORD_BITS-1:0] b2;
  logic                 eob_b;
  logic                 out_load;
  logic                 final_word;

  assign final_word = (rem == NUM_BITS'(1));
  assign out_load   = (rem != '0) && (!out_valid || out_ready);
  assign burst_free = (rem == '0) || (final_word && out_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (burst.load) begin
        rem <= burst.num;
      end else if (out_load) begin
        rem <= rem - NUM_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value        <= b0;
      last_of_item <= final_word;
      block_done   <= final_word && eob_b;
    end
    if (burst.load) begin
      b0    <= burst.v0;
      b1    <= burst.v1;
      b2    <= burst.v2;
      eob_b <= burst.eob;
    end else if (out_load) begin
      b0 <= b1;
      b1 <= b2;
    end
  end

endmodule

[rtl/core/zero_run_length_encoder_unit.sv]
// ----------------------------------------------------------------------------
// zero_run_length_encoder_unit
// Zero run-length encoder for 16-bit print-head words: literals pass,
// zero runs leave as the pair (0, count).
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    word, end_of_block
//  out      output     out_valid / out_ready  value, last_of_item, block_done
//  cfg      input      cfg_valid / cfg_ready  cfg_data (run limit)
//
//  An input word produces 0 to 3 results; the output register sends one per
//  cycle unless out_ready stalls it, and the next burst loads as the last
//  result of the current one moves into the output register.
//  A result passes the input, burst and output registers in turn.
//  rst (synchronous) clears the counter, run limit to 65000, and all valids.
//  A stalled output holds the burst; the input register then fills and
//  in_ready drops.
// ----------------------------------------------------------------------------
module zero_run_length_encoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [zrle_pkg::WORD_BITS-1:0] word,
  input  logic                           end_of_block,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [zrle_pkg::WORD_BITS-1:0] value,
  output logic                           last_of_item,
  output logic                           block_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [zrle_pkg::CNT_BITS-1:0]  cfg_data
);
  import zrle_pkg::*;

  burst_t burst;
  logic   burst_free;

  zrle_encode u_encode (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .word         (word),
    .end_of_block (end_of_block),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .burst_free   (burst_free),
    .burst        (burst)
  );

  zrle_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .burst        (burst),
    .burst_free   (burst_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .last_of_item (last_of_item),
    .block_done   (block_done)
  );

endmodule

[rtl/core/zrle_checker.sv]
// ----------------------------------------------------------------------------
// zrle_checker
// Port-level checks on the zero run-length encoder, bound to the top level.
// ----------------------------------------------------------------------------
module zrle_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [zrle_pkg::WORD_BITS-1:0] value,
  input logic                           last_of_item,
  input logic                           block_done
);

  // block end is always the last result of its item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_done |-> last_of_item)
    else $error("block_done without last_of_item");

  // the run marker is never the last result of its item
  a_marker_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && value == '0 |-> !last_of_item)
    else $error("run marker flagged as last result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) &&
      $stable(last_of_item) && $stable(block_done))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind zero_run_length_encoder_unit zrle_checker u_zrle_checker (.*);
